// ----- hw/rtl/pfa_pkg.sv -----
// Shared types and constants of the page frame allocator.
package pfa_pkg;

  localparam int unsigned CFG_W      = 17;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned BIT_W      = 6;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 8'd1;

  localparam logic [CFG_W-1:0] FIRST_FREE_RST = 17'd256;
  localparam logic [CFG_W-1:0] PAGE_COUNT_RST = 17'd16384;
  localparam logic [CNT_W-1:0] COUNT_MAX      = '1;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_DONE        = 2'd0,
    ST_OOM         = 2'd1,
    ST_BAD_RELEASE = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [ADDR_W-1:0]  page_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  granted_addr;
    status_e            status;
    logic [CNT_W-1:0]   free_left;
  } rsp_t;

  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  bit_idx;
  } ffs_t;

endpackage

// ----- hw/rtl/pfa_map_ram.sv -----
// Page in-use map storage: one write port, one registered read port.
module pfa_map_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [pfa_pkg::WORD_W-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [pfa_pkg::WORD_W-1:0] wr_data_i
);
  import pfa_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ----- hw/rtl/pfa_ffs.sv -----
// Lowest set bit search over one map word.
module pfa_ffs (
  input  logic [pfa_pkg::WORD_W-1:0] cand_i,
  output pfa_pkg::ffs_t              res_o
);
  import pfa_pkg::*;

  logic [WORD_W-1:0] lowest;

  // isolate the lowest set bit, then encode the one-hot word
  assign lowest = cand_i & (~cand_i + WORD_W'(1));

  always_comb begin
    res_o.found   = |cand_i;
    res_o.bit_idx = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (lowest[b]) begin
        res_o.bit_idx = res_o.bit_idx | BIT_W'(b);
      end
    end
  end

endmodule

// ----- hw/rtl/page_frame_allocator_top.sv -----
// Top level of the first-fit page frame allocator.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------
//  request   | in        | start, busy                | req_i (req_type, page_addr)
//  response  | out       | rsp_valid_o (one cycle)    | rsp_o (granted_addr, status,
//            |           |                            |        free_left)
//  config    | in        | cfg_valid_i, cfg_ready_o   | cfg_index_i, cfg_data_i
//
// A request transaction completes when start is high and busy is low.
// Allocate reads 64-page map words, one word per cycle, from the search start
// (the later of the hint word and the word holding first_free_page) up to the
// first word with a free page, or up to the last word on out of memory, through
// the single map read port, and then answers.
// Release reads the word, then writes it back; a release out of range and an
// allocate on an empty range answer straight from idle, with no map read.
// After reset and after every register write the map is cleared one word per
// cycle, ceil(MAX_PAGES / 64) words (1024 by default), with busy high.
// The response strobe cannot be stalled; each response shows for one cycle.
module page_frame_allocator_top #(
  parameter int unsigned MAX_PAGES = 65536
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  pfa_pkg::req_t                  req_i,
  output pfa_pkg::rsp_t                  rsp_o,
  output logic                           rsp_valid_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pfa_pkg::*;

  localparam int unsigned NWORDS = (MAX_PAGES + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [31:0] MAX_PAGES_W = 32'(MAX_PAGES);
  localparam logic [AW-1:0] LAST_CLR  = AW'(NWORDS - 1);
  localparam logic [BIT_W-1:0] BIT_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_CLEAR   = 4'b0010,
    S_ALLOC   = 4'b0100,
    S_RELEASE = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   ffp_q, ffp_d;
  logic [CFG_W-1:0]   pc_q, pc_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [AW-1:0]      hint_q, hint_d;
  logic [AW-1:0]      word_q, word_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [AW-1:0]      clr_q, clr_d;
  rsp_t               rsp_q, rsp_d;
  logic               rsp_valid_q, rsp_valid_d;

  // map port controls
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [WORD_W-1:0]  rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [WORD_W-1:0]  wr_data;

  // range bookkeeping
  logic [31:0]        ffp32, pc32, lim32, last32, rel_idx32;
  logic               range_empty, rel_ok;
  logic [CNT_W-1:0]   reload, count_inc, count_dec;
  logic [AW-1:0]      ffp_word, last_word, start_word, rel_word, word_nxt;
  logic [BIT_W-1:0]   ffp_bit, last_bit;
  logic [WORD_W-1:0]  lo_mask, hi_mask, cand, bit_set, bit_clr;
  ffs_t               ffs;

  pfa_map_ram #(
    .DEPTH (NWORDS),
    .AW    (AW)
  ) u_map (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  pfa_ffs u_ffs (
    .cand_i (cand),
    .res_o  (ffs)
  );

  // Effective scan limit is page_count clamped to the map size.
  assign ffp32       = 32'(ffp_q);
  assign pc32        = 32'(pc_q);
  assign lim32       = (pc32 > MAX_PAGES_W) ? MAX_PAGES_W : pc32;
  assign range_empty = (ffp32 >= lim32);
  assign reload      = range_empty ? '0 : CNT_W'(lim32 - ffp32);
  assign last32      = lim32 - 32'd1;

  // word/bit split of the range ends; only used when the range is non-empty
  assign ffp_word  = AW'(ffp32 >> BIT_W);
  assign ffp_bit   = ffp_q[BIT_W-1:0];
  assign last_word = AW'(last32 >> BIT_W);
  assign last_bit  = last32[BIT_W-1:0];

  // Every word below the hint is full, so the first-fit search may start there.
  assign start_word = (hint_q > ffp_word) ? hint_q : ffp_word;
  assign word_nxt   = word_q + AW'(1);

  assign rel_idx32 = 32'(req_i.page_addr >> PAGE_SHIFT);
  assign rel_ok    = (rel_idx32 >= ffp32) && (rel_idx32 < lim32);
  assign rel_word  = AW'(rel_idx32 >> BIT_W);

  // Mask off pages below first_free_page and at or above the limit.
  assign lo_mask = (word_q == ffp_word)  ? ({WORD_W{1'b1}} << ffp_bit) : '1;
  assign hi_mask = (word_q == last_word) ? ({WORD_W{1'b1}} >> (BIT_MAX - last_bit)) : '1;
  assign cand    = ~rd_data & lo_mask & hi_mask;

  assign bit_set = WORD_W'(1) << ffs.bit_idx;
  assign bit_clr = WORD_W'(1) << bit_q;

  // saturating free counter
  assign count_dec = (count_q == '0) ? '0 : count_q - CNT_W'(1);
  assign count_inc = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    ffp_d       = ffp_q;
    pc_d        = pc_q;
    count_d     = count_q;
    hint_d      = hint_q;
    word_d      = word_q;
    bit_d       = bit_q;
    clr_d       = clr_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = word_q;
    wr_en       = 1'b0;
    wr_addr     = word_q;
    wr_data     = rd_data;

    case (state_q)
      S_CLEAR: begin
        // sweep the map; reload the counter on the last word
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == LAST_CLR) begin
          state_d = S_IDLE;
          count_d = reload;
          hint_d  = '0;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (req_i.req_type == REQ_ALLOC) begin
            if (range_empty) begin
              rsp_d       = '{granted_addr: '0, status: ST_OOM, free_left: count_q};
              rsp_valid_d = 1'b1;
            end else begin
              rd_en   = 1'b1;
              rd_addr = start_word;
              word_d  = start_word;
              state_d = S_ALLOC;
            end
          end else begin
            if (rel_ok) begin
              rd_en   = 1'b1;
              rd_addr = rel_word;
              word_d  = rel_word;
              bit_d   = req_i.page_addr[PAGE_SHIFT +: BIT_W];
              state_d = S_RELEASE;
            end else begin
              rsp_d       = '{granted_addr: '0, status: ST_BAD_RELEASE, free_left: count_q};
              rsp_valid_d = 1'b1;
            end
          end
        end
      end
      S_ALLOC: begin
        if (ffs.found) begin
          // claim the page and write the word back
          wr_en       = 1'b1;
          wr_data     = rd_data | bit_set;
          count_d     = count_dec;
          hint_d      = word_q;
          rsp_d       = '{granted_addr: ADDR_W'({word_q, ffs.bit_idx}) << PAGE_SHIFT,
                          status: ST_DONE, free_left: count_dec};
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (word_q == last_word) begin
          rsp_d       = '{granted_addr: '0, status: ST_OOM, free_left: count_q};
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          // advance to the next word, read issued this cycle
          rd_en   = 1'b1;
          rd_addr = word_nxt;
          word_d  = word_nxt;
        end
      end
      S_RELEASE: begin
        if (rd_data[bit_q]) begin
          wr_en       = 1'b1;
          wr_data     = rd_data & ~bit_clr;
          count_d     = count_inc;
          hint_d      = (word_q < hint_q) ? word_q : hint_q;
          rsp_d       = '{granted_addr: '0, status: ST_DONE, free_left: count_inc};
        end else begin
          rsp_d       = '{granted_addr: '0, status: ST_BAD_RELEASE, free_left: count_q};
        end
        rsp_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Register write: take the value and restart with a fresh clear sweep.
    if (cfg_valid_i) begin
      if (cfg_index_i == REG_FIRST_FREE) begin
        ffp_d   = cfg_data_i[CFG_W-1:0];
        state_d = S_CLEAR;
        clr_d   = '0;
      end else if (cfg_index_i == REG_PAGE_COUNT) begin
        pc_d    = cfg_data_i[CFG_W-1:0];
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ffp_q       <= FIRST_FREE_RST;
      pc_q        <= PAGE_COUNT_RST;
      count_q     <= '0;
      hint_q      <= '0;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ffp_q       <= ffp_d;
      pc_q        <= pc_d;
      count_q     <= count_d;
      hint_q      <= hint_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    bit_q  <= bit_d;
    rsp_q  <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the first-fit page frame allocator.
`timescale 1ns / 100ps

module tb_top;
  import pfa_pkg::*;

  // Pages that the block instance manages (its default MAX_PAGES).
  localparam int unsigned NUM_PAGES = 65536;
  // Register index past the end of the register list; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_MAP = 8'hFF;
  // Quiet cycles after the last response: longer than the longest allocate scan.
  localparam int unsigned END_SETTLE = 1100;

  // Tracks the page map, the registers and the free count. Every accepted
  // request pushes the response it must produce, and responses retire those
  // in order.
  class frame_ledger;
    bit               page_held [NUM_PAGES];
    logic [CFG_W-1:0] first_page;
    logic [CFG_W-1:0] page_total;
    logic [CNT_W-1:0] free_cnt;
    int unsigned      held_pages[$];
    rsp_t             expected_rsps[$];
    int               errors;

    function new();
      first_page = FIRST_FREE_RST;
      page_total = PAGE_COUNT_RST;
      errors     = 0;
      restart();
    endfunction

    // Scan bound: page_count clamped to the map size.
    function int unsigned scan_limit();
      return (page_total > NUM_PAGES) ? NUM_PAGES : int'(page_total);
    endfunction

    function void restart();
      int unsigned lim;
      lim = scan_limit();
      foreach (page_held[i]) page_held[i] = 1'b0;
      held_pages.delete();
      free_cnt = (lim > first_page) ? CNT_W'(lim - first_page) : '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_FIRST_FREE) begin
        first_page = data[CFG_W-1:0];
      end else if (idx == REG_PAGE_COUNT) begin
        page_total = data[CFG_W-1:0];
      end else begin
        return;
      end
      restart();
    endfunction

    function void note_request(req_t req);
      int unsigned lim;
      int unsigned idx;
      int unsigned k;
      rsp_t        exp;
      lim        = scan_limit();
      exp        = '0;
      exp.status = ST_DONE;
      if (req.req_type == REQ_ALLOC) begin
        // First fit: lowest clear page at or above the first allocatable one.
        idx = first_page;
        while (idx < lim && page_held[idx]) idx++;
        if (idx < lim) begin
          page_held[idx] = 1'b1;
          held_pages.push_back(idx);
          if (free_cnt != 0) free_cnt--;
          exp.granted_addr = ADDR_W'(idx << PAGE_SHIFT);
        end else begin
          exp.status = ST_OOM;
        end
      end else begin
        idx = req.page_addr >> PAGE_SHIFT;
        if (idx < first_page || idx >= lim || !page_held[idx]) begin
          exp.status = ST_BAD_RELEASE;
        end else begin
          page_held[idx] = 1'b0;
          k = 0;
          while (k < held_pages.size() && held_pages[k] != idx) k++;
          if (k < held_pages.size()) held_pages.delete(k);
          if (free_cnt != COUNT_MAX) free_cnt++;
        end
      end
      exp.free_left = free_cnt;
      expected_rsps.push_back(exp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (expected_rsps.size() == 0) begin
        errors++;
        $display("%0t: response with none expected: granted_addr %h status %0d free_left %0d",
                 $time, got.granted_addr, got.status, got.free_left);
        return;
      end
      exp = expected_rsps.pop_front();
      if (got.granted_addr !== exp.granted_addr) begin
        errors++;
        $display("%0t: granted_addr mismatch: expected %h, actual %h",
                 $time, exp.granted_addr, got.granted_addr);
      end
      if (got.status !== exp.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, exp.status, got.status);
      end
      if (got.free_left !== exp.free_left) begin
        errors++;
        $display("%0t: free_left mismatch: expected %0d, actual %0d",
                 $time, exp.free_left, got.free_left);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  req_t                  req_i;
  rsp_t                  rsp_o;
  logic                  rsp_valid_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  frame_ledger ledger = new();
  // Phases with steady_phase set send back to back with no gaps.
  bit          steady_phase;

  page_frame_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // The response strobe lasts one cycle and cannot be held off: check it at
  // the edge that ends that cycle.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) ledger.check_response(rsp_o);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_phase) return 0;
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold start low for a gap; with no gap, start stays high for the next
  // transaction so it is never dropped and raised in the same step.
  task automatic idle_for(int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Present one request, hold it until the block takes it, then predict it.
  task automatic send_req(req_type_e kind, logic [ADDR_W-1:0] addr);
    req_t r;
    r.req_type = kind;
    r.page_addr = addr;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    ledger.note_request(r);
    idle_for(pick_gap());
  endtask

  // Stop sending and wait until every expected response has come back.
  task automatic drain();
    start <= 1'b0;
    while (ledger.expected_rsps.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // One register transaction; the caller drops cfg_valid_i after the last one.
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.write_reg(idx, data);
  endtask

  // Reprogram both registers with the block idle. Upper data bits beyond the
  // register width are random and must be dropped by the block.
  task automatic configure(int unsigned first, int unsigned total);
    logic [CFG_DATA_W-1:0] data;
    drain();
    data = $urandom();
    data[CFG_W-1:0] = first[CFG_W-1:0];
    write_cfg(REG_FIRST_FREE, data);
    data = $urandom();
    data[CFG_W-1:0] = total[CFG_W-1:0];
    write_cfg(REG_PAGE_COUNT, data);
    cfg_valid_i <= 1'b0;
  endtask

  // Pick a range: mostly small windows anywhere in the map, plus empty
  // ranges, windows clamped at the top of the map and one wide range.
  task automatic random_config();
    int unsigned first;
    int unsigned total;
    case ($urandom_range(0, 6))
      0, 1: begin
        first = $urandom_range(0, NUM_PAGES - 64);
        total = first + $urandom_range(1, 64);
      end
      2: begin
        first = $urandom_range(0, NUM_PAGES);
        total = $urandom_range(0, first);
      end
      3: begin
        first = NUM_PAGES - $urandom_range(1, 40);
        total = $urandom_range(NUM_PAGES, 131071);
      end
      4: begin
        first = $urandom_range(0, 200);
        total = NUM_PAGES;
      end
      default: begin
        first = $urandom_range(0, NUM_PAGES - 4);
        total = first + $urandom_range(1, 3);
      end
    endcase
    configure(first, total);
  endtask

  // Mostly well-formed traffic: allocates and releases of held pages, with
  // some releases near the range edges (double, unheld, out of range) and
  // some fully random addresses.
  task automatic run_phase(int unsigned n_items);
    int unsigned roll;
    int unsigned page;
    int unsigned lo;
    int unsigned hi;
    for (int unsigned k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50 || (roll < 85 && ledger.held_pages.size() == 0)) begin
        send_req(REQ_ALLOC, $urandom());
      end else if (roll < 85) begin
        page = ledger.held_pages[$urandom_range(0, ledger.held_pages.size() - 1)];
        send_req(REQ_RELEASE, (page << PAGE_SHIFT) | $urandom_range(0, 4095));
      end else if (roll < 94) begin
        lo = (ledger.first_page > 2) ? ledger.first_page - 2 : 0;
        hi = ((ledger.scan_limit() > ledger.first_page) ?
              ledger.scan_limit() : ledger.first_page) + 2;
        page = $urandom_range(lo, hi);
        send_req(REQ_RELEASE, (page << PAGE_SHIFT) | $urandom_range(0, 4095));
      end else begin
        send_req(REQ_RELEASE, $urandom());
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_i        = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    steady_phase = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset range: first fit, reuse of a freed page, double release, and
    // releases below the range, far above it, at its limit and of an unheld page.
    send_req(REQ_ALLOC, '0);
    send_req(REQ_ALLOC, 32'hFFFF_FFFF);
    send_req(REQ_RELEASE, 32'h0010_0FFF);
    send_req(REQ_RELEASE, 32'h0010_0000);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RELEASE, 32'h0000_0000);
    send_req(REQ_RELEASE, 32'hFFFF_FFFF);
    send_req(REQ_RELEASE, 32'h0400_0000);
    send_req(REQ_RELEASE, 32'h0012_C000);

    // Page count above the map clamps to the map: six pages at the top,
    // exhaust them, then release the last page of the map twice.
    configure(NUM_PAGES - 6, 131071);
    repeat (7) send_req(REQ_ALLOC, '0);
    send_req(REQ_RELEASE, 32'h0FFF_F000);
    send_req(REQ_RELEASE, 32'h0FFF_FABC);

    // Empty ranges: nothing configured, and first page at the very top.
    configure(0, 0);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RELEASE, 32'h0000_0000);
    configure(NUM_PAGES, NUM_PAGES);
    send_req(REQ_ALLOC, '0);

    // Whole map: page zero is allocatable.
    configure(0, NUM_PAGES);
    send_req(REQ_ALLOC, '0);
    send_req(REQ_RELEASE, 32'h0FFF_F000);
    send_req(REQ_RELEASE, 32'h0000_0000);

    // Random phases, every third one with no gaps. Halfway through phase 3,
    // drain completely and write an index past the register list, which
    // must leave the allocator state untouched.
    for (int unsigned ph = 0; ph < 8; ph++) begin
      random_config();
      steady_phase = (ph % 3 == 2);
      if (ph == 3) begin
        run_phase(25);
        drain();
        write_cfg(REG_OUT_OF_MAP, $urandom());
        cfg_valid_i <= 1'b0;
        run_phase(25);
      end else begin
        run_phase(50);
      end
    end

    drain();
    repeat (END_SETTLE) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.expected_rsps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
